// ===== src/led_pulse_stream_decoder_core_macros.svh =====
// ----------------------------------------------------------------------------
// LED pulse stream decoder - assertion macros
// Concurrent assertion wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef LED_PULSE_STREAM_DECODER_CORE_MACROS_SVH
`define LED_PULSE_STREAM_DECODER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPSD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("lpsd: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LPSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("lpsd: next-cycle check failed");

`endif

// ===== src/lpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// LED pulse stream decoder - package
// Field widths, stream packing offsets and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package lpsd_pkg;

  localparam int unsigned TS_W       = 48;
  localparam int unsigned GAP_W      = 24;
  localparam int unsigned PULSE_W    = 16;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned CNT_W      = 7;

  // Input tdata: level, timestamp_ns; padded to whole bytes
  localparam int unsigned IN_TDATA_W = 56;

  // Output tdata: led_index, red, green, blue, led_count, overflowed
  localparam int unsigned OUT_IDX_LSB  = 0;
  localparam int unsigned OUT_RED_LSB  = 6;
  localparam int unsigned OUT_GRN_LSB  = 14;
  localparam int unsigned OUT_BLU_LSB  = 22;
  localparam int unsigned OUT_CNT_LSB  = 30;
  localparam int unsigned OUT_OVF_BIT  = 37;
  localparam int unsigned OUT_TDATA_W  = 40;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_RESET_GAP = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ZERO_MIN  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ZERO_MAX  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ONE_MIN   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_ONE_MAX   = 3'd4;

  // Register reset values
  localparam logic [GAP_W-1:0]   RST_RESET_GAP = 24'd50000;
  localparam logic [PULSE_W-1:0] RST_ZERO_MIN  = 16'd200;
  localparam logic [PULSE_W-1:0] RST_ZERO_MAX  = 16'd500;
  localparam logic [PULSE_W-1:0] RST_ONE_MIN   = 16'd550;
  localparam logic [PULSE_W-1:0] RST_ONE_MAX   = 16'd850;

endpackage

`default_nettype wire

// ===== src/led_pulse_stream_decoder_core.sv =====
// ----------------------------------------------------------------------------
// LED pulse stream decoder core
// Decodes timestamped pin edges of a single-wire LED stream into per-LED
// color results, stored in an on-chip color memory and dumped on a reset gap.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Transaction              Payload
// s_axis    in   one edge or poll tick    tuser: command; tdata: level, timestamp_ns
// m_axis    out  one LED of a frame       tdata: led_index, red, green, blue,
//                                          led_count, overflowed; tlast: last
// cfg       in   one register write       cfg_addr_i: index, cfg_data_i: value
//
// An input transaction passes through ST_IDLE, which captures and subtracts
// the timestamp, then ST_EVAL, which classifies and updates the decoder
// (including the color memory write). Each LED of a frame dump passes ST_READ
// for the single-port color memory read, then ST_SEND, which shows the result
// until taken. No input is taken during a dump; cfg writes are taken every cycle.
// rst_ni clears control state asynchronously; the color memory is not cleared,
// entries are read only after they have been written.
// ----------------------------------------------------------------------------
`default_nettype none

module led_pulse_stream_decoder_core #(
  parameter int unsigned MAX_LEDS = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // input stream
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // tdata: [0] level, [48:1] timestamp_ns, [55:49] zero
  input  wire logic [lpsd_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // tuser: [0] command (0 edge, 1 poll)
  input  wire logic                               s_axis_tuser_i,
  // output stream
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // tdata: [5:0] led_index, [13:6] red, [21:14] green, [29:22] blue,
  //        [36:30] led_count, [37] overflowed, [39:38] zero
  output logic [lpsd_pkg::OUT_TDATA_W-1:0]        m_axis_tdata_o,
  output logic                                    m_axis_tlast_o,
  // configuration write channel
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [lpsd_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  wire logic [lpsd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  import lpsd_pkg::*;

  // Memory address width; at least one bit so a single-entry store still works
  localparam int unsigned AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;  // wait for an input transaction
  localparam logic [1:0] ST_EVAL = 2'd1;  // classify pulse, update decoder
  localparam logic [1:0] ST_READ = 2'd2;  // read one stored LED
  localparam logic [1:0] ST_SEND = 2'd3;  // show result, wait for tready

  // Color component codes; the unused code decodes as blue
  localparam logic [1:0] COMP_GREEN = 2'd0;
  localparam logic [1:0] COMP_RED   = 2'd1;

  // Configuration registers
  logic [GAP_W-1:0]   reset_gap_q;
  logic [PULSE_W-1:0] zero_min_q, zero_max_q, one_min_q, one_max_q;

  // Control state
  logic [1:0]         state_q, state_d;
  logic [CNT_W-1:0]   complete_q, complete_d;
  logic [1:0]         comp_q, comp_d;
  logic [2:0]         bitpos_q, bitpos_d;
  logic               frame_sent_q, frame_sent_d;
  logic               ovf_q, ovf_d;
  logic [COLOR_W-1:0] partial_q, partial_d;
  logic [TS_W-1:0]    last_edge_q;
  logic [AW-1:0]      dump_idx_q, dump_idx_d;

  // Captured transaction (payload, no reset)
  logic [TS_W-1:0]    elapsed_q;
  logic               cmd_q;
  logic               level_q;

  // Color memory
  logic [COLOR_W-1:0] color_mem [MAX_LEDS];
  logic [COLOR_W-1:0] rdata_q;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [COLOR_W-1:0] mem_wdata;

  // Input field views
  logic               in_level;
  logic [TS_W-1:0]    in_ts;
  logic               in_fire;
  logic               out_fire;

  assign in_level = s_axis_tdata_i[0];
  assign in_ts    = s_axis_tdata_i[TS_W:1];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (state_q == ST_SEND);
  assign out_fire        = m_axis_tvalid_o && m_axis_tready_i;
  assign cfg_ready_o     = 1'b1;

  // --------------------------------------------------------------------------
  // Pulse classification on the registered elapsed time
  // --------------------------------------------------------------------------
  logic gap_seen;
  logic is_zero;
  logic is_one;
  logic bit_val;
  logic take_bit;
  logic store_full;
  logic last_led;

  assign gap_seen = elapsed_q > TS_W'(reset_gap_q);
  assign is_zero  = (elapsed_q >= TS_W'(zero_min_q)) && (elapsed_q <= TS_W'(zero_max_q));
  assign is_one   = (elapsed_q >= TS_W'(one_min_q)) && (elapsed_q <= TS_W'(one_max_q));
  // Zero window wins where the two windows overlap
  assign bit_val  = !is_zero;
  // A falling edge inside either window, without a reset gap
  assign take_bit = !cmd_q && !gap_seen && !level_q && (is_zero || is_one);
  assign store_full = (complete_q >= CNT_W'(MAX_LEDS));
  assign last_led   = (CNT_W'(dump_idx_q) + CNT_W'(1)) == complete_q;

  // Bit slot inside the packed G,R,B word
  logic [4:0]         slot_base;
  logic [4:0]         slot;
  logic [COLOR_W-1:0] color_next;

  always_comb begin
    case (comp_q)
      COMP_GREEN: slot_base = 5'd16;
      COMP_RED:   slot_base = 5'd8;
      default:    slot_base = 5'd0;
    endcase
    slot       = slot_base + 5'(bitpos_q);
    color_next = partial_q;
    color_next[slot] = bit_val;
  end

  // --------------------------------------------------------------------------
  // Sequencer and decoder update
  // --------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    complete_d   = complete_q;
    comp_d       = comp_q;
    bitpos_d     = bitpos_q;
    frame_sent_d = frame_sent_q;
    ovf_d        = ovf_q;
    partial_d    = partial_q;
    dump_idx_d   = dump_idx_q;
    mem_we       = 1'b0;
    mem_waddr    = complete_q[AW-1:0];
    mem_wdata    = color_next;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EVAL;
        end
      end

      ST_EVAL: begin
        state_d = ST_IDLE;
        if (gap_seen) begin
          // Dump only a frame that has LEDs and was not sent yet
          if (!frame_sent_q && (complete_q != '0)) begin
            dump_idx_d = '0;
            state_d    = ST_READ;
          end
        end else if (take_bit) begin
          frame_sent_d = 1'b0;
          if (store_full) begin
            // Drop the bit, flag the loss, hold the decoder
            ovf_d = 1'b1;
          end else begin
            partial_d = color_next;
            bitpos_d  = bitpos_q - 3'd1;
            if (bitpos_q == 3'd0) begin
              bitpos_d = 3'd7;
              if (comp_q == COMP_GREEN || comp_q == COMP_RED) begin
                comp_d = comp_q + 2'd1;
              end else begin
                // Blue byte done: commit the LED to the store
                comp_d     = COMP_GREEN;
                mem_we     = 1'b1;
                complete_d = complete_q + CNT_W'(1);
              end
            end
          end
        end
      end

      ST_READ: begin
        state_d = ST_SEND;
      end

      ST_SEND: begin
        if (out_fire) begin
          if (last_led) begin
            // Frame done: restart the decoder
            complete_d   = '0;
            comp_d       = COMP_GREEN;
            bitpos_d     = 3'd7;
            partial_d    = '0;
            ovf_d        = 1'b0;
            frame_sent_d = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            dump_idx_d = dump_idx_q + AW'(1);
            state_d    = ST_READ;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      complete_q   <= '0;
      comp_q       <= COMP_GREEN;
      bitpos_q     <= 3'd7;
      frame_sent_q <= 1'b0;
      ovf_q        <= 1'b0;
      partial_q    <= '0;
      dump_idx_q   <= '0;
      last_edge_q  <= '0;
    end else begin
      state_q      <= state_d;
      complete_q   <= complete_d;
      comp_q       <= comp_d;
      bitpos_q     <= bitpos_d;
      frame_sent_q <= frame_sent_d;
      ovf_q        <= ovf_d;
      partial_q    <= partial_d;
      dump_idx_q   <= dump_idx_d;
      // Edges record their time, polls do not
      if (in_fire && !s_axis_tuser_i) begin
        last_edge_q <= in_ts;
      end
    end
  end

  // Capture the transaction; elapsed time wraps modulo 2^48
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      elapsed_q <= in_ts - last_edge_q;
      cmd_q     <= s_axis_tuser_i;
      level_q   <= in_level;
    end
  end

  // --------------------------------------------------------------------------
  // Color memory: writes happen only in ST_EVAL and reads only in ST_READ,
  // so the sequencer itself keeps the two accesses apart.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      color_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      rdata_q <= color_mem[dump_idx_q];
    end
  end

  // --------------------------------------------------------------------------
  // Configuration writes; indexes beyond the list are dropped
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_gap_q <= RST_RESET_GAP;
      zero_min_q  <= RST_ZERO_MIN;
      zero_max_q  <= RST_ZERO_MAX;
      one_min_q   <= RST_ONE_MIN;
      one_max_q   <= RST_ONE_MAX;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_addr_i)
        REG_RESET_GAP: reset_gap_q <= cfg_data_i[GAP_W-1:0];
        REG_ZERO_MIN:  zero_min_q  <= cfg_data_i[PULSE_W-1:0];
        REG_ZERO_MAX:  zero_max_q  <= cfg_data_i[PULSE_W-1:0];
        REG_ONE_MIN:   one_min_q   <= cfg_data_i[PULSE_W-1:0];
        REG_ONE_MAX:   one_max_q   <= cfg_data_i[PULSE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output packing: count and overflow hold steady through the dump
  // --------------------------------------------------------------------------
  always_comb begin
    m_axis_tdata_o = '0;
    m_axis_tdata_o[OUT_IDX_LSB +: IDX_W] = IDX_W'(dump_idx_q);
    m_axis_tdata_o[OUT_RED_LSB +: 8]     = rdata_q[15:8];
    m_axis_tdata_o[OUT_GRN_LSB +: 8]     = rdata_q[23:16];
    m_axis_tdata_o[OUT_BLU_LSB +: 8]     = rdata_q[7:0];
    m_axis_tdata_o[OUT_CNT_LSB +: CNT_W] = complete_q;
    m_axis_tdata_o[OUT_OVF_BIT]          = ovf_q;
  end

  assign m_axis_tlast_o = last_led;

endmodule

`default_nettype wire

// ===== src/lpsd_checker.sv =====
// ----------------------------------------------------------------------------
// LED pulse stream decoder - port checker
// Watches the top-level ports and checks frame output ordering and stalls.
// ----------------------------------------------------------------------------
`default_nettype none

`include "led_pulse_stream_decoder_core_macros.svh"

module lpsd_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tready_o,
  input wire logic                              m_axis_tvalid_o,
  input wire logic                              m_axis_tready_i,
  input wire logic [lpsd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  input wire logic                              m_axis_tlast_o
);

  import lpsd_pkg::*;

  logic [CNT_W-1:0]     led_idx;
  logic [CNT_W-1:0]     led_cnt;
  logic                 idx_is_last;
  logic                 count_ok;
  logic                 out_stall;
  logic [OUT_TDATA_W:0] out_word;

  assign led_idx     = CNT_W'(m_axis_tdata_o[OUT_IDX_LSB +: IDX_W]);
  assign led_cnt     = m_axis_tdata_o[OUT_CNT_LSB +: CNT_W];
  assign idx_is_last = (led_idx + CNT_W'(1)) == led_cnt;
  assign count_ok    = (led_cnt != '0) && (led_idx < led_cnt);
  assign out_stall   = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_word    = {m_axis_tlast_o, m_axis_tdata_o};

  // Hold a stalled result
  `LPSD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid_o && $stable(out_word))

  // tlast marks exactly the LED whose index closes the count
  `LPSD_ASSERT_SAME(a_last_index, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tlast_o == idx_is_last)

  // A dumped frame never reports zero LEDs or an index past its count
  `LPSD_ASSERT_SAME(a_count_range, clk_i, rst_ni, m_axis_tvalid_o, count_ok)

  // Input stays closed while a frame dump is under way
  `LPSD_ASSERT_SAME(a_no_overlap, clk_i, rst_ni, m_axis_tvalid_o, !s_axis_tready_o)

endmodule

bind led_pulse_stream_decoder_core lpsd_checker u_lpsd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire

// ===== verif/led_pulse_stream_decoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// LED pulse stream decoder core - testbench
// Drives timestamped pin edges and poll ticks into the decoder, predicts
// every LED result from a cycle-free model of the bit decoder and the color
// store, and checks each output transaction field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module led_pulse_stream_decoder_core_tb;
  import lpsd_pkg::*;

  localparam int unsigned NUM_LEDS      = 64;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  // Idle time after the last LED result so the block goes quiet; give margin.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned END_WAIT      = 16;
  localparam int unsigned DRAIN_LIMIT   = 20_000;
  localparam int unsigned RANDOM_EVENTS = 470;
  localparam int unsigned RANDOM_LEDS   = 48;
  localparam int unsigned IDLE_PCT      = 34;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned UPPER_W       = CFG_DATA_W - PULSE_W;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  // Indexes past the register list; writes there must change nothing.
  localparam int unsigned REG_UNUSED_LO = 5;
  localparam int unsigned REG_UNUSED_HI = 7;

  typedef enum logic [1:0] {
    CH_GREEN,
    CH_RED,
    CH_BLUE
  } color_channel_e;

  typedef struct packed {
    logic [IDX_W-1:0] led_index;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [CNT_W-1:0] led_count;
    logic             overflowed;
    logic             last;
  } led_result_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports
  // --------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                    s_axis_tvalid_i = 1'b0;
  logic                    s_axis_tready_o;
  logic [IN_TDATA_W-1:0]   s_axis_tdata_i  = '0;
  logic                    s_axis_tuser_i  = 1'b0;
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata_o;
  logic                    m_axis_tlast_o;
  logic                    cfg_valid_i     = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_ADDR_W-1:0]   cfg_addr_i      = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i      = '0;

  always #4 clk_i = ~clk_i;

  led_pulse_stream_decoder_core #(
    .MAX_LEDS(NUM_LEDS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Run bookkeeping
  // --------------------------------------------------------------------------
  int unsigned cycle_count      = 0;
  int unsigned mismatches       = 0;
  int unsigned events_sent      = 0;
  int unsigned leds_predicted   = 0;
  int unsigned leds_checked     = 0;
  int unsigned frames_seen      = 0;
  int unsigned settings_used    = 1;
  int unsigned hold_off_request = 0;
  int unsigned hold_left        = 0;
  bit          steady_flow      = 1'b0;
  logic [TS_W-1:0] now_ns       = '0;

  // --------------------------------------------------------------------------
  // Decoder prediction: registers, bit decoder state and the color store
  // --------------------------------------------------------------------------
  logic [GAP_W-1:0]   gap_ns;
  logic [PULSE_W-1:0] zero_lo_ns;
  logic [PULSE_W-1:0] zero_hi_ns;
  logic [PULSE_W-1:0] one_lo_ns;
  logic [PULSE_W-1:0] one_hi_ns;
  logic [COLOR_W-1:0] stored_colors [NUM_LEDS];
  int unsigned        stored_leds;
  color_channel_e     channel;
  logic [2:0]         bit_pos;
  logic               frame_dumped;
  logic [TS_W-1:0]    prev_edge_ns;
  logic               store_overflow;
  logic [COLOR_W-1:0] color_accum;
  led_result_t        pending_leds [$];

  // Return the frame builder to its idle point (green byte, MSB, empty store).
  function automatic void clear_frame_progress();
    stored_leds    = 0;
    channel        = CH_GREEN;
    bit_pos        = 3'd7;
    color_accum    = '0;
    store_overflow = 1'b0;
  endfunction

  function automatic void apply_register(input logic [CFG_ADDR_W-1:0] addr,
                                         input logic [CFG_DATA_W-1:0] value);
    case (addr)
      REG_RESET_GAP: gap_ns     = value[GAP_W-1:0];
      REG_ZERO_MIN:  zero_lo_ns = value[PULSE_W-1:0];
      REG_ZERO_MAX:  zero_hi_ns = value[PULSE_W-1:0];
      REG_ONE_MIN:   one_lo_ns  = value[PULSE_W-1:0];
      REG_ONE_MAX:   one_hi_ns  = value[PULSE_W-1:0];
      default: ;
    endcase
  endfunction

  // Place one decoded bit; store the LED once its blue byte is full.
  function automatic void shift_in_bit(input logic value);
    int unsigned base;
    frame_dumped = 1'b0;
    if (stored_leds >= NUM_LEDS) begin
      // Store full: drop the bit and flag it, without advancing.
      store_overflow = 1'b1;
      return;
    end
    case (channel)
      CH_GREEN: base = 16;
      CH_RED:   base = 8;
      default:  base = 0;
    endcase
    color_accum[base + bit_pos] = value;
    if (bit_pos != 3'd0) begin
      bit_pos = bit_pos - 3'd1;
    end else if (channel != CH_BLUE) begin
      bit_pos = 3'd7;
      channel = (channel == CH_GREEN) ? CH_RED : CH_BLUE;
    end else begin
      bit_pos = 3'd7;
      channel = CH_GREEN;
      stored_colors[stored_leds] = color_accum;
      stored_leds++;
    end
  endfunction

  // Queue one result per stored LED when the idle gap is long enough.
  function automatic void dump_frame(input logic [TS_W-1:0] elapsed);
    led_result_t res;
    int unsigned k;
    if (elapsed <= gap_ns || frame_dumped || stored_leds == 0) return;
    for (k = 0; k < stored_leds; k++) begin
      res.led_index  = k[IDX_W-1:0];
      res.red        = stored_colors[k][15:8];
      res.green      = stored_colors[k][23:16];
      res.blue       = stored_colors[k][7:0];
      res.led_count  = stored_leds[CNT_W-1:0];
      res.overflowed = store_overflow;
      res.last       = (k + 1 == stored_leds);
      pending_leds.push_back(res);
      leds_predicted++;
    end
    frame_dumped = 1'b1;
    clear_frame_progress();
  endfunction

  function automatic void decode_pin_event(input logic cmd, input logic level,
                                           input logic [TS_W-1:0] stamp);
    logic [TS_W-1:0] elapsed;
    elapsed = stamp - prev_edge_ns;  // wraps modulo 2^48
    if (cmd == CMD_POLL) begin
      dump_frame(elapsed);
      return;
    end
    prev_edge_ns = stamp;
    if (elapsed > gap_ns) begin
      // A gap edge only ever closes a frame; it never carries a bit.
      dump_frame(elapsed);
      return;
    end
    if (level == 1'b0) begin
      // Zero window wins where the two windows overlap.
      if (elapsed >= zero_lo_ns && elapsed <= zero_hi_ns) shift_in_bit(1'b0);
      else if (elapsed >= one_lo_ns && elapsed <= one_hi_ns) shift_in_bit(1'b1);
    end
  endfunction

  initial begin
    gap_ns       = RST_RESET_GAP;
    zero_lo_ns   = RST_ZERO_MIN;
    zero_hi_ns   = RST_ZERO_MAX;
    one_lo_ns    = RST_ONE_MIN;
    one_hi_ns    = RST_ONE_MAX;
    frame_dumped = 1'b0;
    prev_edge_ns = '0;
    clear_frame_progress();
  end

  // --------------------------------------------------------------------------
  // Output side: check each accepted transaction, then pick next tready
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_led_result();
    led_result_t want;
    if (pending_leds.size() == 0) begin
      $display("%0t: unexpected LED result, expected none, got tdata=%h tlast=%b",
               $time, m_axis_tdata_o, m_axis_tlast_o);
      mismatches++;
      return;
    end
    want = pending_leds.pop_front();
    check_field("led_index", want.led_index, m_axis_tdata_o[OUT_IDX_LSB +: IDX_W]);
    check_field("red", want.red, m_axis_tdata_o[OUT_RED_LSB +: 8]);
    check_field("green", want.green, m_axis_tdata_o[OUT_GRN_LSB +: 8]);
    check_field("blue", want.blue, m_axis_tdata_o[OUT_BLU_LSB +: 8]);
    check_field("led_count", want.led_count, m_axis_tdata_o[OUT_CNT_LSB +: CNT_W]);
    check_field("overflowed", want.overflowed, m_axis_tdata_o[OUT_OVF_BIT]);
    check_field("last", want.last, m_axis_tlast_o);
    leds_checked++;
    if (want.last) frames_seen++;
  endtask

  always @(posedge clk_i) begin
    // Take a hold-off request and count it down here, one cycle at a time.
    if (hold_off_request != 0) begin
      hold_left        = hold_off_request;
      hold_off_request = 0;
    end
    if (m_axis_tvalid_o && m_axis_tready_i) check_led_result();
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= steady_flow || ($urandom_range(99, 0) >= IDLE_PCT);
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d LED results still due",
               $time, cycle_count, pending_leds.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Input side: one transaction per call, predicted when accepted
  // --------------------------------------------------------------------------
  task automatic send_event(input logic cmd, input logic level,
                            input logic [TS_W-1:0] stamp);
    if (!steady_flow && $urandom_range(99, 0) < IDLE_PCT) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    // Leave tvalid high afterwards so back-to-back transactions stay back to back.
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {{(IN_TDATA_W - TS_W - 1){1'b0}}, stamp, level};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    decode_pin_event(cmd, level, stamp);
    events_sent++;
  endtask

  // Drop tvalid and wait out every predicted LED, then let the block go quiet.
  task automatic wait_for_leds();
    s_axis_tvalid_i <= 1'b0;
    while (pending_leds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic pin_edge(input logic level, input logic [TS_W-1:0] delta_ns);
    now_ns = now_ns + delta_ns;
    send_event(CMD_EDGE, level, now_ns);
  endtask

  task automatic poll_tick(input logic [TS_W-1:0] delta_ns);
    now_ns = now_ns + delta_ns;
    send_event(CMD_POLL, 1'($urandom_range(1, 0)), now_ns);
  endtask

  function automatic logic [TS_W-1:0] pulse_width(input logic value);
    if (value) return TS_W'($urandom_range(one_hi_ns, one_lo_ns));
    return TS_W'($urandom_range(zero_hi_ns, zero_lo_ns));
  endfunction

  // One bit as a high pulse: optional rising edge after a low time no longer than the
  // gap, then the falling edge that the decoder classifies.
  task automatic send_bit(input logic value, input bit with_rise);
    int unsigned low_max;
    low_max = (gap_ns < 1000) ? gap_ns : 1000;
    if (with_rise) pin_edge(1'b1, TS_W'($urandom_range(low_max, 0)));
    pin_edge(1'b0, pulse_width(value));
  endtask

  // Green, red, blue, each MSB first.
  task automatic send_led(input logic [COLOR_W-1:0] color, input int unsigned rise_pct);
    int i;
    for (i = COLOR_W - 1; i >= 0; i--) send_bit(color[i], $urandom_range(99, 0) < rise_pct);
  endtask

  task automatic close_frame(input bit by_poll);
    logic [TS_W-1:0] delta;
    delta = TS_W'(gap_ns) + TS_W'($urandom_range(2000, 0)) + 48'd1;
    if (by_poll) poll_tick(delta);
    else pin_edge(1'($urandom_range(1, 0)), delta);
  endtask

  task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_register(addr, value);
  endtask

  // Write all five registers back to back, plus junk to the unused indexes.
  // Junk upper bits on the 16-bit registers must be masked off.
  task automatic program_registers(input logic [GAP_W-1:0] gap,
                                   input logic [PULSE_W-1:0] zlo,
                                   input logic [PULSE_W-1:0] zhi,
                                   input logic [PULSE_W-1:0] olo,
                                   input logic [PULSE_W-1:0] ohi);
    logic [UPPER_W-1:0] upper;
    int unsigned        a;
    for (a = REG_UNUSED_LO; a <= REG_UNUSED_HI; a++)
      write_register(a[CFG_ADDR_W-1:0], CFG_DATA_W'($urandom()));
    upper = UPPER_W'($urandom());
    write_register(REG_RESET_GAP, gap);
    write_register(REG_ZERO_MIN, {upper, zlo});
    upper = UPPER_W'($urandom());
    write_register(REG_ZERO_MAX, {upper, zhi});
    upper = UPPER_W'($urandom());
    write_register(REG_ONE_MIN, {upper, olo});
    upper = UPPER_W'($urandom());
    write_register(REG_ONE_MAX, {upper, ohi});
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset-value windows: exact boundaries, widths just outside, rising edges,
  // a poll at exactly the gap, a repeated poll, and a gap that finds only a
  // half-built LED.
  task automatic test_pulse_windows();
    int i;
    pin_edge(1'b1, 48'd100000);
    pin_edge(1'b0, 48'd200);   // zero, lower bound
    pin_edge(1'b0, 48'd500);   // zero, upper bound
    pin_edge(1'b0, 48'd550);   // one, lower bound
    pin_edge(1'b0, 48'd850);   // one, upper bound
    pin_edge(1'b0, 48'd199);
    pin_edge(1'b0, 48'd501);
    pin_edge(1'b0, 48'd549);
    pin_edge(1'b0, 48'd851);
    pin_edge(1'b1, 48'd300);   // rising edge in the zero window: no bit
    pin_edge(1'b0, 48'd0);
    for (i = 0; i < 20; i++) send_bit(1'($urandom_range(1, 0)), i[0]);
    poll_tick(TS_W'(gap_ns));  // exactly the gap: hold the frame
    poll_tick(48'd1);          // one past: dump it
    poll_tick(48'd5000);       // already sent: nothing more
    wait_for_leds();
    for (i = 0; i < 10; i++) send_bit(1'($urandom_range(1, 0)), 1'b1);
    pin_edge(1'b1, TS_W'(gap_ns) + 48'd1); // nothing complete: keep the partial LED
    for (i = 0; i < 14; i++) send_bit(1'($urandom_range(1, 0)), 1'b0);
    close_frame(1'b0);
    wait_for_leds();
  endtask

  task automatic test_timestamp_wrap();
    now_ns = 48'hFFFF_FFFF_FF00;
    pin_edge(1'b1, 48'd0);
    send_led(COLOR_W'($urandom()), 50);
    send_led(COLOR_W'($urandom()), 50);
    close_frame(1'b1);
    wait_for_leds();
  endtask

  task automatic test_register_extremes();
    int i;
    logic [COLOR_W-1:0] color;
    // Overlapping windows: zero must win inside the overlap.
    program_registers(24'd3000, 16'd100, 16'd700, 16'd500, 16'd900);
    color = COLOR_W'($urandom());
    pin_edge(1'b1, 48'd4000);
    for (i = COLOR_W - 1; i >= 0; i--) begin
      if (color[i]) pin_edge(1'b0, TS_W'($urandom_range(900, 701)));
      else pin_edge(1'b0, TS_W'($urandom_range(700, 500)));
    end
    close_frame(1'b1);
    wait_for_leds();

    // All-ones gap; zero only at the widest pulse, one for anything below it.
    program_registers(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
    color = COLOR_W'($urandom());
    for (i = COLOR_W - 1; i >= 0; i--) begin
      if (color[i]) pin_edge(1'b0, TS_W'($urandom_range(16'hFFFE, 0)));
      else pin_edge(1'b0, 48'd65535);
    end
    poll_tick(48'd16777215);   // equal to the gap: hold
    close_frame(1'b1);
    wait_for_leds();

    // All-zero registers: only edges at the same instant decode, as zeros.
    program_registers(24'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    pin_edge(1'b1, 48'd1);
    for (i = 0; i < COLOR_W; i++) pin_edge(1'b0, 48'd0);
    pin_edge(1'b1, 48'd0);
    poll_tick(48'd1);
    pin_edge(1'b0, 48'd1);     // gap edge with nothing left to send
    wait_for_leds();
  endtask

  // Fill the store, overflow it, then stall the dump at the output while the
  // next frame keeps coming so that the input side backs up.
  task automatic test_full_store();
    int i;
    program_registers(RST_RESET_GAP, RST_ZERO_MIN, RST_ZERO_MAX, RST_ONE_MIN, RST_ONE_MAX);
    pin_edge(1'b1, 48'd60000);
    steady_flow = 1'b1;
    for (i = 0; i < NUM_LEDS; i++) begin
      if (i == NUM_LEDS / 2) steady_flow = 1'b0;
      send_led(COLOR_W'($urandom()), 0);
    end
    for (i = 0; i < 5; i++) send_bit(1'($urandom_range(1, 0)), 1'b0);
    hold_off_request = HOLD_CYCLES;
    close_frame(1'b0);
    for (i = 0; i < 30; i++) send_bit(1'($urandom_range(1, 0)), 1'b1);
    close_frame(1'b1);
    wait_for_leds();
  endtask

  // Mostly well-formed frames with random colors; noise and broken frames mixed in.
  task automatic send_random_frame();
    int unsigned n_leds;
    int unsigned rise_pct;
    int unsigned pick;
    int unsigned led;
    int          i;
    logic [COLOR_W-1:0] color;
    n_leds   = ($urandom_range(9, 0) == 0) ? $urandom_range(8, 4) : $urandom_range(3, 1);
    rise_pct = $urandom_range(100, 0);
    for (led = 0; led < n_leds; led++) begin
      color = COLOR_W'($urandom());
      for (i = COLOR_W - 1; i >= 0; i--) begin
        pick = $urandom_range(999, 0);
        if (pick < 40) pin_edge(1'b0, TS_W'($urandom_range(1200, 0)));
        else if (pick < 70) poll_tick(TS_W'($urandom_range((gap_ns < 800) ? gap_ns : 800, 0)));
        else if (pick < 90) pin_edge(1'b1, TS_W'($urandom_range(400, 0)));
        else if (pick < 93) begin
          // Break off mid-LED.
          close_frame(1'($urandom_range(1, 0)));
          return;
        end
        send_bit(color[i], $urandom_range(99, 0) < rise_pct);
      end
    end
    if ($urandom_range(4, 0) == 0)
      for (i = $urandom_range(10, 1); i > 0; i--) send_bit(1'($urandom_range(1, 0)), 1'b1);
    if ($urandom_range(9, 0) == 0) poll_tick(TS_W'(gap_ns));
    close_frame(1'($urandom_range(1, 0)));
    if ($urandom_range(3, 0) == 0)
      poll_tick(TS_W'(gap_ns) + TS_W'($urandom_range(500, 0)) + 48'd1);
  endtask

  task automatic test_random_traffic();
    int unsigned start_events;
    int unsigned start_leds;
    int unsigned phase;
    int unsigned frames;
    int unsigned zlo;
    int unsigned zhi;
    int unsigned olo;
    int unsigned ohi;
    int unsigned gap;
    logic [63:0] jump;
    start_events = events_sent;
    start_leds   = leds_predicted;
    phase        = 0;
    while (events_sent - start_events < RANDOM_EVENTS ||
           leds_predicted - start_leds < RANDOM_LEDS) begin
      wait_for_leds();
      zlo = $urandom_range(400, 0);
      zhi = zlo + $urandom_range(300, 0);
      olo = ($urandom_range(9, 0) == 0) ? zlo + $urandom_range(zhi - zlo, 0)
                                        : zhi + $urandom_range(200, 1);
      ohi = olo + $urandom_range(500, 0);
      gap = ($urandom_range(3, 0) == 0) ? $urandom_range(24'hFFFFFF, 24'h800000)
                                        : ohi + 1 + $urandom_range(60000, 0);
      program_registers(GAP_W'(gap), PULSE_W'(zlo), PULSE_W'(zhi),
                        PULSE_W'(olo), PULSE_W'(ohi));
      steady_flow = (phase == 2);
      // Jump to a random point of the timeline; it reads as a long gap.
      jump   = {$urandom(), $urandom()};
      now_ns = jump[TS_W-1:0];
      for (frames = $urandom_range(3, 1); frames > 0; frames--) send_random_frame();
      phase++;
    end
    steady_flow = 1'b0;
    wait_for_leds();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned waited;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_pulse_windows();
    test_timestamp_wrap();
    test_register_extremes();
    test_full_store();
    test_random_traffic();

    waited = 0;
    while (pending_leds.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (END_WAIT) @(posedge clk_i);
    if (pending_leds.size() != 0) begin
      $display("%0t: LED results missing, expected %0d more, got none",
               $time, pending_leds.size());
      mismatches++;
    end

    $display("Covered %0d edge and poll transactions, %0d LED results in %0d frames,",
             events_sent, leds_checked, frames_seen);
    $display("over %0d register settings, a full store with overflow and a wrapped clock.",
             settings_used);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
